/* rtl/energy_gated_token_bucket_macros.svh */
// Assertion helpers for the checker file of the token bucket shaper.
`ifndef ENERGY_GATED_TOKEN_BUCKET_MACROS_SVH
`define ENERGY_GATED_TOKEN_BUCKET_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define EGTB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define EGTB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

/* rtl/egtb_pkg.sv */
package egtb_pkg;

	localparam int DEF_QUEUE_DEPTH = 256;
	localparam int DEF_MAX_BUCKET  = 64;

	localparam int MODE_W   = 3;
	localparam int TAG_W    = 16;
	localparam int ENERGY_W = 32;
	localparam int KIND_W   = 3;
	localparam int WHOLE_W  = 7;
	localparam int QFILL_W  = 9;

	localparam int RATE_W   = 17;
	localparam int BUCKET_W = 7;
	localparam int COST_W   = 16;
	localparam int FRAC_W   = 16;
	localparam int TOKEN_W  = BUCKET_W + FRAC_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = RATE_W;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_TOKEN_RATE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_ENERGY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_ENERGY  = 2'd3;

	// Request modes.
	localparam logic [MODE_W-1:0] MODE_ENQ   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_TICK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ADD   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SUB   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_START = 3'd4;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_ACCEPTED  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DROPPED   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RELEASED  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_IDLE_TICK = 3'd3;
	localparam logic [KIND_W-1:0] KIND_UPDATED   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_SATURATED = 3'd5;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [TAG_W-1:0]    packet_tag;
		logic [ENERGY_W-1:0] energy_amount;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [TAG_W-1:0]    released_tag;
		logic                last;
		logic [WHOLE_W-1:0]  tokens_whole;
		logic [ENERGY_W-1:0] battery_level;
		logic [QFILL_W-1:0]  queue_fill;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic enq;
		logic tick_init;
		logic release_step;
		logic bat_add;
		logic bat_sub;
		logic start;
		logic no_release;
		logic emit_release;
		logic emit_single;
	} egtb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic can_release;
		logic out_free;
	} egtb_status_t;

endpackage

/* rtl/energy_gated_token_bucket.sv */
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_stall    in_item_t
// result    out        result_valid / result_stall out_item_t
// cfg       in         cfg_we                     cfg_index, cfg_data
//
// Enqueue, battery add, battery subtract and start each pass through their own state and
// then the single-result state; a tick adds tokens, then checks whether a tag can leave and
// either gives an idle result or, per release, reads the tag store and then emits it.
// The next request is accepted the cycle after the last result enters the output register.
// Reset clears pointers, fill count, tokens, battery, config (bucket size to one), not the tag store.
// A stalled result holds the sequencer in place.
module energy_gated_token_bucket
	import egtb_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int MAX_BUCKET  = DEF_MAX_BUCKET
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  in_item_t              item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output out_item_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	egtb_cmd_t    cmd;
	egtb_status_t status;

	egtb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.mode       (item.mode),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	egtb_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MAX_BUCKET  (MAX_BUCKET)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

/* rtl/egtb_datapath.sv */
module egtb_datapath
	import egtb_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int MAX_BUCKET  = DEF_MAX_BUCKET
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_item_t              item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  egtb_cmd_t             cmd,
	output egtb_status_t          status,
	input  logic                  result_stall,
	output logic                  result_valid,
	output out_item_t             result
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int NW = $clog2(MAX_BUCKET + 1);

	logic [RATE_W-1:0]   rate_q;
	logic [BUCKET_W-1:0] bucket_q;
	logic [COST_W-1:0]   data_energy_q;
	logic [COST_W-1:0]   ack_energy_q;

	in_item_t            item_q;
	logic [AW-1:0]       head_q;
	logic [AW-1:0]       tail_q;
	logic [FW-1:0]       fill_q;
	logic [TOKEN_W-1:0]  token_q;
	logic [ENERGY_W-1:0] battery_q;
	logic [ENERGY_W-1:0] copy_q;
	logic [NW-1:0]       n_q;
	logic [KIND_W-1:0]   kind_q;
	logic [TAG_W-1:0]    tag_q;
	logic [TAG_W-1:0]    rdata_q;
	logic                res_valid_q;
	out_item_t           res_q;

	logic [TAG_W-1:0]    tag_mem [QUEUE_DEPTH];

	logic [COST_W:0]     cost;
	logic [BUCKET_W-1:0] eff_bucket;
	logic [TOKEN_W-1:0]  cap;
	logic [TOKEN_W:0]    token_sum;
	logic [ENERGY_W:0]   bat_sum;
	logic                full;
	logic                can_release;
	logic                out_free;
	logic [AW-1:0]       head_next;
	logic [AW-1:0]       tail_next;

	assign cost       = {1'b0, data_energy_q} + {1'b0, ack_energy_q};
	assign eff_bucket = (bucket_q > BUCKET_W'(MAX_BUCKET)) ? BUCKET_W'(MAX_BUCKET) : bucket_q;
	assign cap        = {eff_bucket, {FRAC_W{1'b0}}};
	assign token_sum  = {1'b0, token_q} + (TOKEN_W + 1)'(rate_q);
	assign bat_sum    = {1'b0, battery_q} + {1'b0, item_q.energy_amount};
	assign full       = (fill_q == FW'(QUEUE_DEPTH));
	assign head_next  = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_next  = (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	// A tag may leave when the queue holds one, the per-tick energy copy still
	// covers a data and ack pair, a whole token is left and the burst limit is
	// not reached.
	assign can_release = (fill_q != '0) && (copy_q >= ENERGY_W'(cost))
		&& (token_q[TOKEN_W-1:FRAC_W] != '0) && (n_q < NW'(MAX_BUCKET));
	assign out_free    = !res_valid_q || !result_stall;

	assign status.can_release = can_release;
	assign status.out_free    = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q        <= '0;
			bucket_q      <= BUCKET_W'(1);
			data_energy_q <= '0;
			ack_energy_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TOKEN_RATE:  rate_q        <= cfg_data;
				REG_BUCKET_SIZE: bucket_q      <= cfg_data[BUCKET_W-1:0];
				REG_DATA_ENERGY: data_energy_q <= cfg_data[COST_W-1:0];
				REG_ACK_ENERGY:  ack_energy_q  <= cfg_data[COST_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
			token_q   <= '0;
			battery_q <= '0;
			copy_q    <= '0;
			n_q       <= '0;
		end else begin
			if (cmd.enq && !full) begin
				tail_q <= tail_next;
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.tick_init) begin
				token_q <= (token_sum > {1'b0, cap}) ? cap : token_sum[TOKEN_W-1:0];
				copy_q  <= battery_q;
				n_q     <= '0;
			end
			if (cmd.release_step) begin
				head_q  <= head_next;
				fill_q  <= fill_q - 1'b1;
				copy_q  <= copy_q - ENERGY_W'(cost);
				token_q <= token_q - {{(BUCKET_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};
				n_q     <= n_q + 1'b1;
			end
			if (cmd.bat_add) begin
				battery_q <= bat_sum[ENERGY_W] ? '1 : bat_sum[ENERGY_W-1:0];
			end
			if (cmd.bat_sub) begin
				battery_q <= (item_q.energy_amount > battery_q) ? '0
					: battery_q - item_q.energy_amount;
			end
			if (cmd.start) begin
				token_q   <= cap;
				battery_q <= ENERGY_W'(eff_bucket) * ENERGY_W'(cost);
			end
		end
	end

	// Request and single-result payload; no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.enq) begin
			kind_q <= full ? KIND_DROPPED : KIND_ACCEPTED;
			tag_q  <= full ? item_q.packet_tag : '0;
		end
		if (cmd.bat_add) begin
			kind_q <= bat_sum[ENERGY_W] ? KIND_SATURATED : KIND_UPDATED;
			tag_q  <= '0;
		end
		if (cmd.bat_sub) begin
			kind_q <= (item_q.energy_amount > battery_q) ? KIND_SATURATED : KIND_UPDATED;
			tag_q  <= '0;
		end
		if (cmd.start) begin
			kind_q <= KIND_UPDATED;
			tag_q  <= '0;
		end
		if (cmd.no_release) begin
			kind_q <= KIND_IDLE_TICK;
			tag_q  <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enq && !full) begin
			tag_mem[tail_q] <= item_q.packet_tag;
		end
		if (cmd.release_step) begin
			rdata_q <= tag_mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit_release || cmd.emit_single) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_release || cmd.emit_single) begin
			res_q.kind          <= cmd.emit_release ? KIND_RELEASED : kind_q;
			res_q.released_tag  <= cmd.emit_release ? rdata_q : tag_q;
			// The final release of a tick is the one after which no more can go.
			res_q.last          <= cmd.emit_release ? !can_release : 1'b1;
			res_q.tokens_whole  <= token_q[TOKEN_W-1:FRAC_W];
			res_q.battery_level <= battery_q;
			res_q.queue_fill    <= QFILL_W'(fill_q);
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

/* rtl/egtb_ctrl.sv */
module egtb_ctrl
	import egtb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic [MODE_W-1:0] mode,
	output logic              item_stall,
	input  egtb_status_t      status,
	output egtb_cmd_t         cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_ENQ    = 4'd1;
	localparam logic [3:0] ST_ADD    = 4'd2;
	localparam logic [3:0] ST_SUB    = 4'd3;
	localparam logic [3:0] ST_START  = 4'd4;
	localparam logic [3:0] ST_TADD   = 4'd5;
	localparam logic [3:0] ST_TCHK   = 4'd6;
	localparam logic [3:0] ST_TRD    = 4'd7;
	localparam logic [3:0] ST_TEMIT  = 4'd8;
	localparam logic [3:0] ST_SINGLE = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					unique case (mode)
						MODE_ENQ:   state_d = ST_ENQ;
						MODE_TICK:  state_d = ST_TADD;
						MODE_ADD:   state_d = ST_ADD;
						MODE_SUB:   state_d = ST_SUB;
						MODE_START: state_d = ST_START;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_ENQ: begin
				cmd.enq = 1'b1;
				state_d = ST_SINGLE;
			end
			ST_ADD: begin
				cmd.bat_add = 1'b1;
				state_d     = ST_SINGLE;
			end
			ST_SUB: begin
				cmd.bat_sub = 1'b1;
				state_d     = ST_SINGLE;
			end
			ST_START: begin
				cmd.start = 1'b1;
				state_d   = ST_SINGLE;
			end
			ST_TADD: begin
				cmd.tick_init = 1'b1;
				state_d       = ST_TCHK;
			end
			ST_TCHK: begin
				if (status.can_release) begin
					state_d = ST_TRD;
				end else begin
					cmd.no_release = 1'b1;
					state_d        = ST_SINGLE;
				end
			end
			ST_TRD: begin
				cmd.release_step = 1'b1;
				state_d          = ST_TEMIT;
			end
			ST_TEMIT: begin
				if (status.out_free) begin
					cmd.emit_release = 1'b1;
					state_d          = status.can_release ? ST_TRD : ST_IDLE;
				end
			end
			ST_SINGLE: begin
				if (status.out_free) begin
					cmd.emit_single = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/egtb_checker.sv */
`include "energy_gated_token_bucket_macros.svh"

module egtb_checker
	import egtb_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_stall,
	input in_item_t  item,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result
);

	// A result waiting on a stalled receiver stays offered.
	`EGTB_ASSERT_NXT(a_result_held, result_valid && result_stall, result_valid)

	// A request with a defined mode keeps the block busy in the next cycle.
	`EGTB_ASSERT_NXT(a_busy_after_request, item_valid && !item_stall && (item.mode == MODE_ENQ || item.mode == MODE_TICK || item.mode == MODE_ADD || item.mode == MODE_SUB || item.mode == MODE_START), item_stall)

	// Only releases can be followed by more results of the same request.
	`EGTB_ASSERT_IMP(a_single_is_last, result_valid && result.kind != KIND_RELEASED, result.last)

	// A release always leaves room in the queue behind it.
	`EGTB_ASSERT_IMP(a_release_frees, result_valid && result.kind == KIND_RELEASED, result.queue_fill < QUEUE_DEPTH)

endmodule

bind energy_gated_token_bucket egtb_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
